FILE: design/mlfq_pkg.sv
package mlfq_pkg;

    // default sizing of the slot table
    localparam int DEF_PROC_SLOTS = 16;
    localparam int DEF_MAX_LEVELS = 4;
    localparam int DEF_BURST_BITS = 16;

    // fixed field widths
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int LVL_CFG_W   = 3;
    localparam int PERIOD_W    = 16;
    localparam int QUANT_W     = 16;
    localparam int QUANT_NUM   = 4;
    localparam int TICK_W      = 16;
    localparam int TIME_W      = 32;
    localparam int SLOT_ID_W   = 4;
    localparam int BURST_LEN_W = 16;
    localparam int LEVEL_OUT_W = 3;

    localparam int DEF_ENTRY_W = DEF_BURST_BITS + $clog2(DEF_MAX_LEVELS + 1) + TICK_W;

    // register reset values
    localparam logic [LVL_CFG_W-1:0] RST_LEVEL_COUNT  = 3'd4;
    localparam logic [PERIOD_W-1:0]  RST_BOOST_PERIOD = 16'd100;
    localparam logic [QUANT_W-1:0]   RST_QUANTUM1     = 16'd2;
    localparam logic [QUANT_W-1:0]   RST_QUANTUM2     = 16'd4;
    localparam logic [QUANT_W-1:0]   RST_QUANTUM3     = 16'd8;
    localparam logic [QUANT_W-1:0]   RST_QUANTUM4     = 16'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_COUNT  = 3'd0,
        CFG_BOOST_PERIOD = 3'd1,
        CFG_QUANTUM1     = 3'd2,
        CFG_QUANTUM2     = 3'd3,
        CFG_QUANTUM3     = 3'd4,
        CFG_QUANTUM4     = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_ADMIT = 1'b1
    } t_action;

    typedef struct packed {
        t_action                  action;
        logic [SLOT_ID_W-1:0]     slot_id;
        logic [BURST_LEN_W-1:0]   burst_length;
    } t_in_word;

    typedef struct packed {
        logic                     cpu_busy;
        logic [SLOT_ID_W-1:0]     served_slot;
        logic [LEVEL_OUT_W-1:0]   served_level;
        logic                     finished;
        logic                     admit_ok;
        logic [TIME_W-1:0]        time_now;
    } t_out_word;

    // settings as the sequencer sees them; period and quanta already floored at one
    typedef struct packed {
        logic [LVL_CFG_W-1:0]                 level_count;
        logic [PERIOD_W-1:0]                  boost_period;
        logic [QUANT_NUM-1:0][QUANT_W-1:0]    quantum;
        logic                                 period_load;
        logic [PERIOD_W-1:0]                  period_new;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADMIT,
        ST_TICK,
        ST_SCAN,
        ST_RUN,
        ST_SWEEP,
        ST_DONE
    } t_state;

endpackage

FILE: design/mlfq_chan_if.sv
interface mlfq_chan_if #(
    parameter type t_word = logic
);
    logic  valid;
    logic  ready;
    t_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/mlfq_tick_scheduler.sv
// Channel   Dir  Word         Fields
// in_chan   in   t_in_word    action, slot_id, burst_length
// out_chan  out  t_out_word   cpu_busy, served_slot, served_level, finished, admit_ok, time_now
// cfg       in   write port   i_cfg_we, i_cfg_idx, i_cfg_data
//
// One word at a time. Admit: table read, write back, hand off. Tick: read the
// holder, run it and write it back; a scan of all PROC_SLOTS slots comes first when
// a new holder is picked and a sweep of all slots follows on a boost, both paced by
// the single read port of the slot table.
// Synchronous active-low reset; the slot table reads as free right after reset.
// A waiting result sits in the output register while the next word is taken.
module mlfq_tick_scheduler #(
    parameter int PROC_SLOTS = mlfq_pkg::DEF_PROC_SLOTS,
    parameter int MAX_LEVELS = mlfq_pkg::DEF_MAX_LEVELS,
    parameter int BURST_BITS = mlfq_pkg::DEF_BURST_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    mlfq_chan_if.sink                         i_in_chan,
    mlfq_chan_if.source                       o_out_chan,
    input  logic                              i_cfg_we,
    input  logic [mlfq_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mlfq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mlfq_pkg::*;

    localparam int SLOT_W = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;
    localparam int LVL_W  = $clog2(MAX_LEVELS + 1);
    localparam int ENT_W  = BURST_BITS + LVL_W + TICK_W;

    logic [LVL_CFG_W-1:0]              r_level_count;
    logic [PERIOD_W-1:0]               r_boost_period;
    logic [QUANT_NUM-1:0][QUANT_W-1:0] r_quantum;
    t_cfg                              cfg;

    logic                  r_out_valid;
    t_out_word             r_out_word;
    logic                  res_valid, res_take, in_ready;
    t_out_word             res;

    logic                  rd_en, wr_en;
    logic [SLOT_W-1:0]     rd_addr, wr_addr;
    logic [ENT_W-1:0]      wr_data, rd_data;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count  <= RST_LEVEL_COUNT;
            r_boost_period <= RST_BOOST_PERIOD;
            r_quantum[0]   <= RST_QUANTUM1;
            r_quantum[1]   <= RST_QUANTUM2;
            r_quantum[2]   <= RST_QUANTUM3;
            r_quantum[3]   <= RST_QUANTUM4;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LEVEL_COUNT:  r_level_count  <= LVL_CFG_W'(i_cfg_data);
                CFG_BOOST_PERIOD: r_boost_period <= i_cfg_data;
                CFG_QUANTUM1:     r_quantum[0]   <= i_cfg_data;
                CFG_QUANTUM2:     r_quantum[1]   <= i_cfg_data;
                CFG_QUANTUM3:     r_quantum[2]   <= i_cfg_data;
                CFG_QUANTUM4:     r_quantum[3]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero period or quantum acts as one
    always_comb begin
        cfg.level_count  = r_level_count;
        cfg.boost_period = (r_boost_period == '0) ? PERIOD_W'(1) : r_boost_period;
        for (int i = 0; i < QUANT_NUM; i++) begin
            cfg.quantum[i] = (r_quantum[i] == '0) ? QUANT_W'(1) : r_quantum[i];
        end
        cfg.period_load = i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_BOOST_PERIOD);
        cfg.period_new  = (i_cfg_data == '0) ? PERIOD_W'(1) : PERIOD_W'(i_cfg_data);
    end

    mlfq_slot_mem #(
        .DEPTH (PROC_SLOTS),
        .WIDTH (ENT_W)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    mlfq_ctrl #(
        .PROC_SLOTS (PROC_SLOTS),
        .MAX_LEVELS (MAX_LEVELS),
        .BURST_BITS (BURST_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_chan.valid),
        .i_item      (i_in_chan.data),
        .o_in_ready  (in_ready),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .i_rd_data   (rd_data)
    );

    assign i_in_chan.ready = in_ready;

    // output register: loads when empty or drained this cycle
    assign res_take = res_valid && (!r_out_valid || o_out_chan.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_out_chan.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_word <= res;
        end
    end

    assign o_out_chan.valid = r_out_valid;
    assign o_out_chan.data  = r_out_word;

endmodule

FILE: design/mlfq_slot_mem.sv
module mlfq_slot_mem #(
    parameter int DEPTH = mlfq_pkg::DEF_PROC_SLOTS,
    parameter int WIDTH = mlfq_pkg::DEF_ENTRY_W,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rvalid;

    // storage and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    // per-entry written flags; an unwritten entry reads as zero (free slot)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rvalid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rvalid ? r_rdata : '0;

endmodule

FILE: design/mlfq_ctrl.sv
module mlfq_ctrl #(
    parameter int PROC_SLOTS = mlfq_pkg::DEF_PROC_SLOTS,
    parameter int MAX_LEVELS = mlfq_pkg::DEF_MAX_LEVELS,
    parameter int BURST_BITS = mlfq_pkg::DEF_BURST_BITS,
    localparam int SLOT_W = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1,
    localparam int LVL_W  = $clog2(MAX_LEVELS + 1),
    localparam int ENT_W  = BURST_BITS + LVL_W + mlfq_pkg::TICK_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mlfq_pkg::t_cfg        i_cfg,
    // input word
    input  logic                  i_in_valid,
    input  mlfq_pkg::t_in_word    i_item,
    output logic                  o_in_ready,
    // result handoff to the output register
    output logic                  o_res_valid,
    output mlfq_pkg::t_out_word   o_res,
    input  logic                  i_res_take,
    // slot table port
    output logic                  o_rd_en,
    output logic [SLOT_W-1:0]     o_rd_addr,
    output logic                  o_wr_en,
    output logic [SLOT_W-1:0]     o_wr_addr,
    output logic [ENT_W-1:0]      o_wr_data,
    input  logic [ENT_W-1:0]      i_rd_data
);
    import mlfq_pkg::*;

    localparam int CNT_W = $clog2(PROC_SLOTS + 1);

    t_state               r_state, n_state;
    t_in_word             r_item, n_item;
    t_out_word            r_res, n_res;
    logic                 r_holding, n_holding;
    logic [SLOT_W-1:0]    r_holder, n_holder;
    logic [SLOT_W-1:0]    r_last, n_last;
    logic [TIME_W-1:0]    r_tick, n_tick;
    logic [PERIOD_W-1:0]  r_countdown, n_countdown;
    logic [SLOT_W-1:0]    r_ptr, n_ptr;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_eval, n_eval;
    logic [SLOT_W-1:0]    r_eval_addr, n_eval_addr;
    logic                 r_found, n_found;
    logic [SLOT_W-1:0]    r_best, n_best;
    logic [LVL_W-1:0]     r_best_lvl, n_best_lvl;

    logic [BURST_BITS-1:0] rd_rem, rem1, burst_m;
    logic [LVL_W-1:0]      rd_lvl, lvl1, lvls_used;
    logic [TICK_W-1:0]     rd_tk, tk1;
    logic [SLOT_W-1:0]     ptr_inc, last_inc;
    logic                  boost, slot_ok, scan_end;

    assign rd_rem = i_rd_data[ENT_W-1 -: BURST_BITS];
    assign rd_lvl = i_rd_data[TICK_W +: LVL_W];
    assign rd_tk  = i_rd_data[TICK_W-1:0];

    function automatic logic [QUANT_W-1:0] quantum_of(input logic [LVL_W-1:0] lvl,
                                                      input t_cfg cfg);
        logic [QUANT_W-1:0] q;
        if (int'(lvl) <= 1) begin
            q = cfg.quantum[0];
        end else if (int'(lvl) == 2) begin
            q = cfg.quantum[1];
        end else if (int'(lvl) == 3) begin
            q = cfg.quantum[2];
        end else begin
            q = cfg.quantum[3];
        end
        return q;
    endfunction

    // levels in use, clamped to 1..MAX_LEVELS
    always_comb begin
        if (i_cfg.level_count == '0) begin
            lvls_used = LVL_W'(1);
        end else if (int'(i_cfg.level_count) > MAX_LEVELS) begin
            lvls_used = LVL_W'(MAX_LEVELS);
        end else begin
            lvls_used = LVL_W'(i_cfg.level_count);
        end
    end

    // round-robin pointers
    assign ptr_inc  = (r_ptr == SLOT_W'(PROC_SLOTS - 1)) ? '0 : r_ptr + 1'b1;
    assign last_inc = (r_last == SLOT_W'(PROC_SLOTS - 1)) ? '0 : r_last + 1'b1;
    assign scan_end = (r_cnt == CNT_W'(PROC_SLOTS)) && !r_eval;
    assign burst_m  = BURST_BITS'(r_item.burst_length);
    assign slot_ok  = int'(r_item.slot_id) < PROC_SLOTS;

    // state register and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_holding   <= 1'b0;
            r_holder    <= '0;
            r_last      <= SLOT_W'(PROC_SLOTS - 1);
            r_tick      <= '0;
            r_countdown <= RST_BOOST_PERIOD;
            r_cnt       <= '0;
            r_eval      <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_holding   <= n_holding;
            r_holder    <= n_holder;
            r_last      <= n_last;
            r_tick      <= n_tick;
            r_countdown <= n_countdown;
            r_cnt       <= n_cnt;
            r_eval      <= n_eval;
            r_found     <= n_found;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_res       <= n_res;
        r_ptr       <= n_ptr;
        r_eval_addr <= n_eval_addr;
        r_best      <= n_best;
        r_best_lvl  <= n_best_lvl;
    end

    // next state, table accesses and result
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_res       = r_res;
        n_holding   = r_holding;
        n_holder    = r_holder;
        n_last      = r_last;
        n_tick      = r_tick;
        n_countdown = r_countdown;
        n_ptr       = r_ptr;
        n_cnt       = r_cnt;
        n_eval      = r_eval;
        n_eval_addr = r_eval_addr;
        n_found     = r_found;
        n_best      = r_best;
        n_best_lvl  = r_best_lvl;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_ptr;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_eval_addr;
        o_wr_data   = '0;
        boost       = 1'b0;
        rem1        = '0;
        lvl1        = '0;
        tk1         = '0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item = i_item;
                    if (i_item.action == ACT_ADMIT) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = SLOT_W'(i_item.slot_id);
                        n_state   = ST_ADMIT;
                    end else begin
                        n_state = ST_TICK;
                    end
                end
            end

            // slot entry is on the read port: take it if free, the slot id is in range and the burst is non-zero
            ST_ADMIT: begin
                n_res          = '0;
                n_res.time_now = r_tick;
                if (slot_ok && rd_rem == '0 && burst_m != '0) begin
                    o_wr_en        = 1'b1;
                    o_wr_addr      = SLOT_W'(r_item.slot_id);
                    o_wr_data      = {burst_m, LVL_W'(1), TICK_W'(0)};
                    n_res.admit_ok = 1'b1;
                end
                n_state = ST_DONE;
            end

            ST_TICK: begin
                if (r_holding) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_holder;
                    n_state   = ST_RUN;
                end else begin
                    n_ptr   = last_inc;
                    n_cnt   = '0;
                    n_eval  = 1'b0;
                    n_found = 1'b0;
                    n_state = ST_SCAN;
                end
            end

            // one slot per cycle after the last served; lowest live level wins
            ST_SCAN: begin
                if (r_eval && rd_rem != '0 && (!r_found || rd_lvl < r_best_lvl)) begin
                    n_found    = 1'b1;
                    n_best     = r_eval_addr;
                    n_best_lvl = rd_lvl;
                end
                if (r_cnt != CNT_W'(PROC_SLOTS)) begin
                    o_rd_en     = 1'b1;
                    o_rd_addr   = r_ptr;
                    n_eval      = 1'b1;
                    n_eval_addr = r_ptr;
                    n_ptr       = ptr_inc;
                    n_cnt       = r_cnt + 1'b1;
                end else begin
                    n_eval = 1'b0;
                end
                if (scan_end) begin
                    if (r_found) begin
                        n_holding = 1'b1;
                        n_holder  = r_best;
                        o_rd_en   = 1'b1;
                        o_rd_addr = r_best;
                    end
                    n_state = ST_RUN;
                end
            end

            // time advances; a holder entry on the read port runs one tick and is written back
            ST_RUN: begin
                n_tick         = (r_tick == '1) ? r_tick : r_tick + 1'b1;
                boost          = (r_countdown <= PERIOD_W'(1));
                n_countdown    = boost ? i_cfg.boost_period : r_countdown - 1'b1;
                n_res          = '0;
                n_res.time_now = n_tick;
                if (r_holding) begin
                    n_res.cpu_busy     = 1'b1;
                    n_res.served_slot  = SLOT_ID_W'(r_holder);
                    n_res.served_level = LEVEL_OUT_W'(rd_lvl);
                    n_last             = r_holder;
                    rem1 = rd_rem - 1'b1;
                    tk1  = (rd_tk == '1) ? rd_tk : rd_tk + 1'b1;
                    lvl1 = rd_lvl;
                    // boost also lifts a holder still live
                    if (boost && rem1 != '0 && rd_lvl > LVL_W'(1)) begin
                        lvl1 = LVL_W'(1);
                        tk1  = '0;
                    end
                    if (rem1 == '0) begin
                        n_res.finished = 1'b1;
                        n_holding      = 1'b0;
                        lvl1           = '0;
                        tk1            = '0;
                    end else if (tk1 >= quantum_of(lvl1, i_cfg)) begin
                        if (lvl1 < lvls_used) begin
                            lvl1 = lvl1 + 1'b1;
                        end
                        tk1       = '0;
                        n_holding = 1'b0;
                    end
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_holder;
                    o_wr_data = {rem1, lvl1, tk1};
                end
                if (boost) begin
                    n_ptr   = '0;
                    n_cnt   = '0;
                    n_eval  = 1'b0;
                    n_state = ST_SWEEP;
                end else begin
                    n_state = ST_DONE;
                end
            end

            // boost: read one entry; the one read last cycle, if live and not just served, goes to level one
            ST_SWEEP: begin
                if (r_eval && !(r_res.cpu_busy && r_eval_addr == r_last)
                        && rd_rem != '0 && rd_lvl > LVL_W'(1)) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_eval_addr;
                    o_wr_data = {rd_rem, LVL_W'(1), TICK_W'(0)};
                end
                if (r_cnt != CNT_W'(PROC_SLOTS)) begin
                    o_rd_en     = 1'b1;
                    o_rd_addr   = r_ptr;
                    n_eval      = 1'b1;
                    n_eval_addr = r_ptr;
                    n_ptr       = ptr_inc;
                    n_cnt       = r_cnt + 1'b1;
                end else begin
                    n_eval = 1'b0;
                end
                if (scan_end) begin
                    n_state = ST_DONE;
                end
            end

            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // writing the boost period restarts the countdown
        if (i_cfg.period_load) begin
            n_countdown = i_cfg.period_new;
        end
    end

    assign o_res = r_res;

endmodule

FILE: design/mlfq_sva.sv
module mlfq_sva (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  mlfq_pkg::t_out_word  i_out_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word))
        else $error("result word changed while stalled");

    // one word in flight: the sequencer is busy right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while previous word still in work");

    // nothing ran: slot, level and finish flag are zero
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_word.cpu_busy |->
            i_out_word.served_slot == '0 && i_out_word.served_level == '0
            && !i_out_word.finished)
        else $error("idle result carries slot data");

    // on an admit result the finish flag matches the busy flag
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_word.finished || i_out_word.admit_ok) |->
            (i_out_word.finished == i_out_word.cpu_busy) || !i_out_word.admit_ok)
        else $error("inconsistent result flags");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind mlfq_tick_scheduler mlfq_sva u_mlfq_sva (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_chan.valid),
    .i_in_ready  (i_in_chan.ready),
    .i_out_valid (o_out_chan.valid),
    .i_out_ready (o_out_chan.ready),
    .i_out_word  (o_out_chan.data)
);

FILE: bench/tb_top.sv
module tb_top;
    import mlfq_pkg::*;

    localparam int NSLOT      = DEF_PROC_SLOTS;
    // settle margin for the slowest word, with some slack
    localparam int SETTLE     = 2 * DEF_PROC_SLOTS + 16;
    // cycles without any handshake before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 225;

    typedef struct {
        logic      pin;
        t_out_word val;
    } t_pin;

    typedef struct {
        t_in_word  word;
        logic      pin;
        t_out_word want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    mlfq_chan_if #(.t_word(t_in_word))  in_if ();
    mlfq_chan_if #(.t_word(t_out_word)) out_if ();

    mlfq_tick_scheduler u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (in_if),
        .o_out_chan (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // scheduler shadow: slot table, holder, time
    logic [15:0] sl_remain [NSLOT];
    logic [2:0]  sl_level  [NSLOT];
    logic [15:0] sl_used   [NSLOT];
    logic [3:0]  hold_slot;
    logic        hold_on;
    logic [3:0]  last_slot;
    logic [31:0] tick_cnt;
    logic [15:0] boost_left;

    // shadow of the register file
    logic [2:0]  lvl_cfg;
    logic [15:0] period_cfg;
    logic [15:0] quant_cfg [4];

    t_out_word sched_q [$];
    t_pin      pinned_q [$];
    t_row      dir_tab [$];

    int   err_cnt;
    int   idle_cycles;
    logic calm;

    // clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic t_out_word sched_res(input logic busy, input logic [3:0] slot,
                                            input logic [2:0] lvl, input logic fin,
                                            input logic ok, input logic [31:0] tnow);
        t_out_word r;
        r.cpu_busy     = busy;
        r.served_slot  = slot;
        r.served_level = lvl;
        r.finished     = fin;
        r.admit_ok     = ok;
        r.time_now     = tnow;
        return r;
    endfunction

    function automatic t_row mk_row(input t_action a, input logic [3:0] sid,
                                    input logic [15:0] burst, input logic pin,
                                    input t_out_word want);
        t_row r;
        r.word.action       = a;
        r.word.slot_id      = sid;
        r.word.burst_length = burst;
        r.pin               = pin;
        r.want              = want;
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_reg16(input int small_hi);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'd1;
        if (r == 2) return 16'hFFFF;
        return 16'($urandom_range(2, small_hi));
    endfunction

    function automatic t_in_word make_item();
        t_in_word w;
        int r;
        w.slot_id      = 4'($urandom_range(0, 15));
        w.burst_length = 16'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (r < 35) begin
            w.action = ACT_ADMIT;
            r = $urandom_range(0, 99);
            if (r < 75)
                w.burst_length = 16'($urandom_range(1, 12));
            else if (r < 83)
                w.burst_length = 16'd0;
            else if (r < 95)
                w.burst_length = 16'($urandom_range(13, 300));
        end else begin
            w.action = ACT_TICK;
        end
        return w;
    endfunction

    // one word through the scheduler shadow
    task automatic schedule_word(input t_in_word w, output t_out_word r);
        logic [3:0]  s, h, best;
        logic [2:0]  best_lvl, lv, top;
        logic [15:0] q;
        logic        found;
        r = '0;
        if (w.action == ACT_ADMIT) begin
            if (sl_remain[w.slot_id] == 16'd0 && w.burst_length != 16'd0) begin
                sl_remain[w.slot_id] = w.burst_length;
                sl_level[w.slot_id]  = 3'd1;
                sl_used[w.slot_id]   = 16'd0;
                r.admit_ok           = 1'b1;
            end
        end else begin
            if (hold_on && sl_remain[hold_slot] == 16'd0)
                hold_on = 1'b0;
            // lowest live level wins, round robin after the last one served
            if (!hold_on) begin
                found    = 1'b0;
                best     = '0;
                best_lvl = '0;
                for (int k = 1; k <= NSLOT; k++) begin
                    s = last_slot + 4'(k);
                    if (sl_remain[s] != 16'd0 && (!found || sl_level[s] < best_lvl)) begin
                        found    = 1'b1;
                        best     = s;
                        best_lvl = sl_level[s];
                    end
                end
                if (found) begin
                    hold_slot = best;
                    hold_on   = 1'b1;
                end
            end
            if (tick_cnt != 32'hFFFF_FFFF)
                tick_cnt++;
            if (hold_on) begin
                h              = hold_slot;
                r.cpu_busy     = 1'b1;
                r.served_slot  = h;
                r.served_level = sl_level[h];
                last_slot      = h;
                sl_remain[h]   = sl_remain[h] - 16'd1;
                if (sl_used[h] != 16'hFFFF)
                    sl_used[h]++;
            end
            // periodic boost back to level one
            if (boost_left <= 16'd1) begin
                for (int j = 0; j < NSLOT; j++) begin
                    if (sl_remain[j] != 16'd0 && sl_level[j] > 3'd1) begin
                        sl_level[j] = 3'd1;
                        sl_used[j]  = 16'd0;
                    end
                end
                boost_left = (period_cfg == 16'd0) ? 16'd1 : period_cfg;
            end else begin
                boost_left--;
            end
            // finish, or quantum spent: demote and release
            if (r.cpu_busy) begin
                h   = r.served_slot;
                lv  = (sl_level[h] < 3'd1) ? 3'd1 : ((sl_level[h] > 3'd4) ? 3'd4 : sl_level[h]);
                q   = quant_cfg[lv - 3'd1];
                if (q == 16'd0)
                    q = 16'd1;
                top = (lvl_cfg == 3'd0) ? 3'd1
                    : ((lvl_cfg > 3'(DEF_MAX_LEVELS)) ? 3'(DEF_MAX_LEVELS) : lvl_cfg);
                if (sl_remain[h] == 16'd0) begin
                    r.finished = 1'b1;
                    hold_on    = 1'b0;
                    sl_level[h] = 3'd0;
                    sl_used[h]  = 16'd0;
                end else if (sl_used[h] >= q) begin
                    if (sl_level[h] < top)
                        sl_level[h]++;
                    sl_used[h] = 16'd0;
                    hold_on    = 1'b0;
                end
            end
        end
        r.time_now = tick_cnt;
    endtask

    // register write, called just after a falling edge; leaves the enable high
    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = val;
        case (idx)
            CFG_LEVEL_COUNT: lvl_cfg = val[2:0];
            CFG_BOOST_PERIOD: begin
                period_cfg = val;
                boost_left = val;
            end
            CFG_QUANTUM1: quant_cfg[0] = val;
            CFG_QUANTUM2: quant_cfg[1] = val;
            CFG_QUANTUM3: quant_cfg[2] = val;
            CFG_QUANTUM4: quant_cfg[3] = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // present one word, hold it until taken
    task automatic send_word(input t_in_word w, input int gap, input logic pin,
                             input t_out_word val);
        t_pin p;
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        p.pin = pin;
        p.val = val;
        pinned_q.push_back(p);
        in_if.data  = w;
        in_if.valid = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        in_if.valid = 1'b0;
        while (sched_q.size() != 0 || pinned_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // predict on every accepted word, check every accepted result
    always @(posedge i_clk) begin : monitor
        t_pin      p;
        t_out_word pred, want, got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                p = pinned_q.pop_front();
                schedule_word(in_if.data, pred);
                sched_q.push_back(p.pin ? p.val : pred);
            end
            if (out_if.valid && out_if.ready) begin
                got = out_if.data;
                if (sched_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result word: time_now=%0d", got.time_now);
                end else begin
                    want = sched_q.pop_front();
                    if (got.cpu_busy !== want.cpu_busy || got.served_slot !== want.served_slot
                        || got.served_level !== want.served_level
                        || got.finished !== want.finished || got.admit_ok !== want.admit_ok
                        || got.time_now !== want.time_now) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("mismatch exp: busy=%0d slot=%0d lvl=%0d fin=%0d ok=%0d t=%0d",
                                     want.cpu_busy, want.served_slot, want.served_level,
                                     want.finished, want.admit_ok, want.time_now);
                            $display("         got: busy=%0d slot=%0d lvl=%0d fin=%0d ok=%0d t=%0d",
                                     got.cpu_busy, got.served_slot, got.served_level,
                                     got.finished, got.admit_ok, got.time_now);
                        end
                    end
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("mlfq_tick_scheduler regression: fail");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial begin : ready_gen
        int stall;
        stall        = 0;
        out_if.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                out_if.ready = 1'b0;
                stall--;
            end else begin
                out_if.ready = 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall = pick_gap();
            end
        end
    end

    initial begin
        t_in_word    w;
        t_out_word   none;
        logic [15:0] per;
        logic [15:0] q [4];
        logic [2:0]  lc;

        // drive everything known from time zero
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = CFG_LEVEL_COUNT;
        cfg_data     = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        err_cnt      = 0;
        idle_cycles  = 0;
        calm         = 1'b0;
        none         = '0;

        // shadow reset state
        for (int j = 0; j < NSLOT; j++) begin
            sl_remain[j] = '0;
            sl_level[j]  = '0;
            sl_used[j]   = '0;
        end
        hold_slot    = '0;
        hold_on      = 1'b0;
        last_slot    = 4'(NSLOT - 1);
        tick_cnt     = '0;
        lvl_cfg      = RST_LEVEL_COUNT;
        period_cfg   = RST_BOOST_PERIOD;
        boost_left   = RST_BOOST_PERIOD;
        quant_cfg[0] = RST_QUANTUM1;
        quant_cfg[1] = RST_QUANTUM2;
        quant_cfg[2] = RST_QUANTUM3;
        quant_cfg[3] = RST_QUANTUM4;

        // directed rows under the reset settings
        dir_tab.push_back(mk_row(ACT_TICK,  4'd0,  16'd0,    1'b1, sched_res(0, 0, 0, 0, 0, 1)));
        dir_tab.push_back(mk_row(ACT_ADMIT, 4'd0,  16'd0,    1'b1, sched_res(0, 0, 0, 0, 0, 1)));
        dir_tab.push_back(mk_row(ACT_ADMIT, 4'd15, 16'hFFFF, 1'b1, sched_res(0, 0, 0, 0, 1, 1)));
        dir_tab.push_back(mk_row(ACT_ADMIT, 4'd15, 16'd5,    1'b1, sched_res(0, 0, 0, 0, 0, 1)));
        dir_tab.push_back(mk_row(ACT_ADMIT, 4'd0,  16'd1,    1'b1, sched_res(0, 0, 0, 0, 1, 1)));
        dir_tab.push_back(mk_row(ACT_TICK,  4'd0,  16'd0,    1'b1, sched_res(1, 0, 1, 1, 0, 2)));
        dir_tab.push_back(mk_row(ACT_TICK,  4'd0,  16'd0,    1'b1, sched_res(1, 15, 1, 0, 0, 3)));
        dir_tab.push_back(mk_row(ACT_TICK,  4'd0,  16'd0,    1'b1, sched_res(1, 15, 1, 0, 0, 4)));
        dir_tab.push_back(mk_row(ACT_ADMIT, 4'd7,  16'd3,    1'b1, sched_res(0, 0, 0, 0, 1, 4)));
        dir_tab.push_back(mk_row(ACT_TICK,  4'd0,  16'd0,    1'b1, sched_res(1, 7, 1, 0, 0, 5)));
        dir_tab.push_back(mk_row(ACT_TICK,  4'd0,  16'd0,    1'b1, sched_res(1, 7, 1, 0, 0, 6)));
        dir_tab.push_back(mk_row(ACT_TICK,  4'd0,  16'd0,    1'b1, sched_res(1, 15, 2, 0, 0, 7)));
        // a level-one arrival does not preempt the holder
        dir_tab.push_back(mk_row(ACT_ADMIT, 4'd3,  16'd2,    1'b1, sched_res(0, 0, 0, 0, 1, 7)));
        dir_tab.push_back(mk_row(ACT_TICK,  4'd0,  16'd0,    1'b1, sched_res(1, 15, 2, 0, 0, 8)));
        dir_tab.push_back(mk_row(ACT_TICK,  4'hF,  16'hFFFF, 1'b0, none));
        dir_tab.push_back(mk_row(ACT_TICK,  4'd0,  16'd0,    1'b0, none));
        dir_tab.push_back(mk_row(ACT_TICK,  4'd0,  16'd0,    1'b0, none));
        dir_tab.push_back(mk_row(ACT_TICK,  4'd0,  16'd0,    1'b0, none));
        dir_tab.push_back(mk_row(ACT_ADMIT, 4'hA,  16'hAAAA, 1'b0, none));
        dir_tab.push_back(mk_row(ACT_ADMIT, 4'h5,  16'h5555, 1'b0, none));
        dir_tab.push_back(mk_row(ACT_ADMIT, 4'd8,  16'h8000, 1'b0, none));
        dir_tab.push_back(mk_row(ACT_TICK,  4'd0,  16'd0,    1'b0, none));
        dir_tab.push_back(mk_row(ACT_TICK,  4'd0,  16'd0,    1'b0, none));
        dir_tab.push_back(mk_row(ACT_TICK,  4'd0,  16'd0,    1'b0, none));
        dir_tab.push_back(mk_row(ACT_TICK,  4'd0,  16'd0,    1'b0, none));

        // reset
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < dir_tab.size(); i++)
            send_word(dir_tab[i].word, pick_gap(), dir_tab[i].pin, dir_tab[i].want);

        // random phases, each under its own register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drain();
            case (ph)
                0: begin
                    lc = 3'd0; per = 16'd1;
                    q[0] = 16'd0; q[1] = 16'd0; q[2] = 16'd0; q[3] = 16'd0;
                end
                1: begin
                    lc = 3'd7; per = 16'hFFFF;
                    q[0] = 16'hFFFF; q[1] = 16'hFFFF; q[2] = 16'hFFFF; q[3] = 16'hFFFF;
                end
                2: begin
                    lc = 3'd1; per = 16'd0;
                    q[0] = 16'd1; q[1] = 16'd1; q[2] = 16'd1; q[3] = 16'd1;
                end
                default: begin
                    lc  = 3'($urandom_range(0, 7));
                    per = pick_reg16(60);
                    for (int j = 0; j < 4; j++)
                        q[j] = pick_reg16(12);
                end
            endcase
            // upper data bits of the level count are don't-care; toggle them too
            write_reg(CFG_LEVEL_COUNT, {13'($urandom_range(0, 8191)), lc});
            write_reg(CFG_BOOST_PERIOD, per);
            write_reg(CFG_QUANTUM1, q[0]);
            write_reg(CFG_QUANTUM2, q[1]);
            write_reg(CFG_QUANTUM3, q[2]);
            write_reg(CFG_QUANTUM4, q[3]);
            cfg_we = 1'b0;

            for (int n = 0; n < PHASE_LEN; n++) begin
                if (n % 75 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                w = make_item();
                send_word(w, calm ? 0 : pick_gap(), 1'b0, none);
            end
            calm = 1'b0;
        end

        // drain and settle
        in_if.valid = 1'b0;
        while (sched_q.size() != 0 || pinned_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (err_cnt == 0 && sched_q.size() == 0)
            $display("mlfq_tick_scheduler regression: pass");
        else
            $display("mlfq_tick_scheduler regression: fail");
        $finish;
    end

endmodule
